### rtl/fdf_pkg.sv
// Shared constants and types for the fixed-length frame deframer.
package fdf_pkg;

	localparam int BYTE_W          = 8;
	localparam int IDX_W           = 6;
	localparam int MARK_LEN        = 4;
	localparam int FRAME_BYTES_DEF = 56;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [IDX_W-1:0]  idx_t;

	localparam byte_t HEAD_MARK = 8'hFF;
	localparam byte_t TAIL_MARK = 8'hEF;
	localparam byte_t PAD_MARK  = 8'h00;

	// Status from the window to the top level.
	typedef struct packed {
		logic hit;        // this beat completes a valid frame
		logic near_full;  // the next beat may complete a frame
	} win_stat_t;

endpackage

### rtl/fdf_if.sv
// Valid/ready channel interfaces for the received bytes and the payload beats.
interface fdf_byte_if;
	import fdf_pkg::*;

	logic  valid;
	logic  ready;
	byte_t data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface fdf_payload_if;
	import fdf_pkg::*;

	logic  valid;
	logic  ready;
	byte_t payload_byte;
	idx_t  payload_index;
	logic  is_last;

	modport source (output valid, output payload_byte, output payload_index,
		output is_last, input ready);
	modport sink   (input valid, input payload_byte, input payload_index,
		input is_last, output ready);
endinterface

### rtl/fixed_length_frame_deframer_top.sv
// The first payload beat is offered in the cycle after the frame's closing byte is taken.
// Throughput: one byte per ready cycle; a frame gives FRAME_BYTES-8 beats, one per ready cycle.
// During a burst, bytes are still taken until the window holds FRAME_BYTES-1 of them,
// as only then could a further frame complete; the payload holding register sets this.
// Reset (arst_n low, asynchronous) empties the window count and drops any pending burst.
module fixed_length_frame_deframer_top #(
	parameter int FRAME_BYTES = fdf_pkg::FRAME_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	fdf_byte_if.sink      rx,
	fdf_payload_if.source payload
);
	import fdf_pkg::*;

	localparam int PAYLOAD_LEN = FRAME_BYTES - 2 * MARK_LEN;

	win_stat_t                stat;
	byte_t [PAYLOAD_LEN-1:0]  frame_payload;
	logic                     busy;
	logic                     rx_take;

	// A new frame needs a full window, so bytes keep flowing while one is pending.
	assign rx.ready = !busy || !stat.near_full;
	assign rx_take  = rx.valid && rx.ready;

	fdf_window #(.FRAME_BYTES(FRAME_BYTES)) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift_en  (rx_take),
		.data_byte (rx.data_byte),
		.stat      (stat),
		.payload   (frame_payload)
	);

	fdf_burst #(.FRAME_BYTES(FRAME_BYTES)) u_burst (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (rx_take && stat.hit),
		.payload (frame_payload),
		.busy    (busy),
		.tx      (payload)
	);

endmodule

### rtl/fdf_window.sv
// Sliding byte window with fill count and header/tail frame detection.
module fdf_window #(
	parameter int FRAME_BYTES = fdf_pkg::FRAME_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  shift_en,
	input  fdf_pkg::byte_t        data_byte,
	output fdf_pkg::win_stat_t    stat,
	output fdf_pkg::byte_t [FRAME_BYTES-2*fdf_pkg::MARK_LEN-1:0] payload
);
	import fdf_pkg::*;

	localparam int PAYLOAD_LEN = FRAME_BYTES - 2 * MARK_LEN;
	localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FRAME_BYTES);
	localparam logic [CNT_W-1:0] NEAR_CNT = CNT_W'(FRAME_BYTES - 1);

	// Index 0 holds the newest byte, the top index the oldest.
	byte_t [FRAME_BYTES-1:0] win_q;
	byte_t [FRAME_BYTES-1:0] win_nxt;
	logic  [CNT_W-1:0]       count_q;
	logic                    head_ok;
	logic                    tail_ok;

	assign win_nxt = {win_q[FRAME_BYTES-2:0], data_byte};

	// Outer marks of the window as it stands after this beat.
	assign head_ok = (win_nxt[FRAME_BYTES-1] == HEAD_MARK) &&
		(win_nxt[FRAME_BYTES-2] == PAD_MARK) &&
		(win_nxt[FRAME_BYTES-3] == PAD_MARK) &&
		(win_nxt[FRAME_BYTES-4] == PAD_MARK);
	assign tail_ok = (win_nxt[3] == TAIL_MARK) && (win_nxt[2] == PAD_MARK) &&
		(win_nxt[1] == PAD_MARK) && (win_nxt[0] == PAD_MARK);

	assign stat.near_full = (count_q >= NEAR_CNT);
	assign stat.hit       = stat.near_full && head_ok && tail_ok;

	// Payload in arrival order, taken from the window after this beat.
	for (genvar k = 0; k < PAYLOAD_LEN; k++) begin : g_pay
		assign payload[k] = win_nxt[FRAME_BYTES-1-MARK_LEN-k];
	end

	// Byte shift line; its contents only count once the window is full.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			win_q <= win_nxt;
		end
	end

	// Fill count, emptied when a frame is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (shift_en) begin
			if (stat.hit) begin
				count_q <= '0;
			end else if (count_q != FULL_CNT) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

### rtl/fdf_burst.sv
// Payload holding register that plays a taken frame out one beat at a time.
module fdf_burst #(
	parameter int FRAME_BYTES = fdf_pkg::FRAME_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  fdf_pkg::byte_t [FRAME_BYTES-2*fdf_pkg::MARK_LEN-1:0] payload,
	output logic                  busy,
	fdf_payload_if.source         tx
);
	import fdf_pkg::*;

	localparam int   PAYLOAD_LEN = FRAME_BYTES - 2 * MARK_LEN;
	localparam idx_t LAST_IDX    = IDX_W'(PAYLOAD_LEN - 1);

	byte_t [PAYLOAD_LEN-1:0] buf_q;
	idx_t                    idx_q;
	logic                    busy_q;
	logic                    beat_done;

	assign beat_done = busy_q && tx.ready;

	assign busy             = busy_q;
	assign tx.valid         = busy_q;
	assign tx.payload_byte  = buf_q[0];
	assign tx.payload_index = idx_q;
	assign tx.is_last       = (idx_q == LAST_IDX);

	// Payload shift line: load a whole frame, move one byte down per beat.
	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= payload;
		end else if (beat_done) begin
			for (int k = 0; k < PAYLOAD_LEN - 1; k++) begin
				buf_q[k] <= buf_q[k+1];
			end
		end
	end

	// Burst control: busy flag and beat index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (beat_done) begin
			if (idx_q == LAST_IDX) begin
				busy_q <= 1'b0;
				idx_q  <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

### rtl/fdf_checker.sv
// Port-level checks for the deframer, bound to the top level.
module fdf_checker #(
	parameter int FRAME_BYTES = fdf_pkg::FRAME_BYTES_DEF
) (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_ready,
	input fdf_pkg::byte_t out_byte,
	input fdf_pkg::idx_t  out_index,
	input logic           out_last
);
	import fdf_pkg::*;

	localparam idx_t LAST_IDX = IDX_W'(FRAME_BYTES - 2 * MARK_LEN - 1);

	// A stalled beat keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
		$stable(out_index) && $stable(out_last))
		else $error("stalled payload beat changed");

	// The last mark sits exactly on the final payload position.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_last == (out_index == LAST_IDX)))
		else $error("last flag does not match payload index");

	// Within a burst the next beat follows at once with the next index.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=>
		out_valid && (out_index == IDX_W'($past(out_index) + 1'b1)))
		else $error("burst broken or index skipped");

	// A burst starts at index zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (out_index == '0))
		else $error("burst did not start at index zero");

endmodule

bind fixed_length_frame_deframer_top fdf_checker #(.FRAME_BYTES(FRAME_BYTES)) u_fdf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (payload.valid),
	.out_ready (payload.ready),
	.out_byte  (payload.payload_byte),
	.out_index (payload.payload_index),
	.out_last  (payload.is_last)
);

### dv/fixed_length_frame_deframer_checker.sv
// Watches both channels of the frame deframer, predicts every payload beat and checks it.
`timescale 1ns / 1ps

module fixed_length_frame_deframer_checker #(
	parameter int FRAME_BYTES = fdf_pkg::FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	fdf_byte_if         rx,
	fdf_payload_if      payload,
	output int unsigned mismatches,
	output int unsigned beats_pending
);
	import fdf_pkg::*;

	localparam int PAYLOAD_BYTES = FRAME_BYTES - 2 * MARK_LEN;

	typedef struct packed {
		byte_t data;
		idx_t  index;
		logic  last;
	} payload_beat_t;

	// Sliding window of received bytes, oldest first, and how many of them are valid.
	byte_t         window [FRAME_BYTES];
	int unsigned   window_fill;
	payload_beat_t beats_due [$];

	// One line per mismatch, and the count goes up by one.
	task automatic report_mismatch(input string what);
		$display("%0t ns: payload mismatch: %s", $time, what);
		mismatches++;
	endtask

	// True when four bytes starting at pos read first, 00, 00, 00.
	function automatic logic mark_at(input int pos, input byte_t first);
		return window[pos] == first && window[pos + 1] == PAD_MARK &&
			window[pos + 2] == PAD_MARK && window[pos + 3] == PAD_MARK;
	endfunction

	// Takes one received byte into the window and queues the burst of a completed frame.
	function automatic void take_byte(input byte_t b);
		payload_beat_t beat;
		int            i;
		if (window_fill < FRAME_BYTES) begin
			window[window_fill] = b;
			window_fill++;
		end else begin
			for (i = 0; i < FRAME_BYTES - 1; i++) begin
				window[i] = window[i + 1];
			end
			window[FRAME_BYTES - 1] = b;
		end
		if (window_fill != FRAME_BYTES) return;
		if (!mark_at(0, HEAD_MARK) || !mark_at(FRAME_BYTES - MARK_LEN, TAIL_MARK)) return;
		for (i = 0; i < PAYLOAD_BYTES; i++) begin
			beat.data  = window[MARK_LEN + i];
			beat.index = idx_t'(i);
			beat.last  = (i == PAYLOAD_BYTES - 1);
			beats_due  = {beats_due, beat};
		end
		// A frame that has been taken never contributes to a later one.
		for (i = 0; i < FRAME_BYTES; i++) begin
			window[i] = PAD_MARK;
		end
		window_fill = 0;
	endfunction

	// Payload beats are checked before the byte of the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		payload_beat_t want;
		int            i;
		if (!arst_n) begin
			for (i = 0; i < FRAME_BYTES; i++) begin
				window[i] = PAD_MARK;
			end
			window_fill = 0;
			beats_due.delete();
			mismatches    = 0;
			beats_pending = 0;
		end else begin
			if (payload.valid && payload.ready) begin
				if (beats_due.size() == 0) begin
					report_mismatch($sformatf("beat %02h index %0d arrived with nothing due",
						payload.payload_byte, payload.payload_index));
				end else begin
					want = beats_due.pop_front();
					if (payload.payload_byte !== want.data) begin
						report_mismatch($sformatf("byte %02h, expected %02h at index %0d",
							payload.payload_byte, want.data, want.index));
					end
					if (payload.payload_index !== want.index) begin
						report_mismatch($sformatf("index %0d, expected %0d",
							payload.payload_index, want.index));
					end
					if (payload.is_last !== want.last) begin
						report_mismatch($sformatf("last flag %b, expected %b at index %0d",
							payload.is_last, want.last, want.index));
					end
				end
			end
			if (rx.valid && rx.ready) begin
				take_byte(rx.data_byte);
			end
			beats_pending = beats_due.size();
		end
	end

endmodule

### dv/fixed_length_frame_deframer_top_test.sv
// Testbench top for the frame deframer: byte stimulus, payload back-pressure and the verdict.
`timescale 1ns / 1ps

module fixed_length_frame_deframer_top_test;
	import fdf_pkg::*;

	localparam int FRAME_BYTES    = FRAME_BYTES_DEF;
	localparam int PAYLOAD_BYTES  = FRAME_BYTES - 2 * MARK_LEN;
	localparam int TARGET_BYTES   = 130;
	localparam int TARGET_FRAMES  = 2;
	localparam int DRAIN_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT = 2000;

	// Kinds of byte sequence in the random part.
	typedef enum int {
		SEQ_GOOD_FRAME,
		SEQ_MARKED_PAYLOAD,
		SEQ_BAD_HEADER,
		SEQ_BAD_TAIL,
		SEQ_NOISE,
		SEQ_KINDS
	} seq_kind_t;

	localparam byte_t CORNER_BYTES [13] = '{
		8'h00, 8'hFF, 8'hEF, 8'h01, 8'h02, 8'h04, 8'h08,
		8'h10, 8'h20, 8'h40, 8'h80, 8'h7F, 8'hFE
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        quiet = 1'b0;
	int unsigned bytes_sent = 0;
	int unsigned frames_sent = 0;
	int unsigned idle_cycles = 0;
	int unsigned mismatches;
	int unsigned beats_pending;

	fdf_byte_if    rx_if ();
	fdf_payload_if payload_if ();

	fixed_length_frame_deframer_top #(
		.FRAME_BYTES(FRAME_BYTES)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if.sink),
		.payload(payload_if.source)
	);

	fixed_length_frame_deframer_checker #(
		.FRAME_BYTES(FRAME_BYTES)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx           (rx_if),
		.payload      (payload_if),
		.mismatches   (mismatches),
		.beats_pending(beats_pending)
	);

	always #6 clk = ~clk;

	// Offers one byte, after an occasional burst of idle cycles, and waits for its beat.
	task automatic send_byte(input byte_t b);
		int unsigned gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 15);
		end
		if (gap != 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_if.valid     <= 1'b1;
		rx_if.data_byte <= b;
		do @(posedge clk); while (!rx_if.ready);
		bytes_sent++;
	endtask

	// Bytes that look like parts of a header or tail turn up often in noise.
	function automatic byte_t mark_like_byte();
		case ($urandom_range(0, 3))
			0: return HEAD_MARK;
			1: return TAIL_MARK;
			2: return PAD_MARK;
			default: return byte_t'($urandom);
		endcase
	endfunction

	// Builds and sends one frame, either well formed or with one mark byte spoilt.
	task automatic send_frame(input seq_kind_t kind);
		byte_t frame [FRAME_BYTES];
		int    i;
		for (i = 0; i < FRAME_BYTES; i++) begin
			frame[i] = (kind == SEQ_MARKED_PAYLOAD && $urandom_range(0, 2) == 0) ?
				mark_like_byte() : byte_t'($urandom);
		end
		for (i = 0; i < MARK_LEN; i++) begin
			frame[i] = (i == 0) ? HEAD_MARK : PAD_MARK;
			frame[FRAME_BYTES - MARK_LEN + i] = (i == 0) ? TAIL_MARK : PAD_MARK;
		end
		// A whole header and tail inside the payload must not be taken as marks.
		if (kind == SEQ_MARKED_PAYLOAD) begin
			for (i = 0; i < MARK_LEN; i++) begin
				frame[MARK_LEN + i] = (i == 0) ? HEAD_MARK : PAD_MARK;
				frame[FRAME_BYTES - 2 * MARK_LEN + i] = (i == 0) ? TAIL_MARK : PAD_MARK;
			end
		end
		if (kind == SEQ_BAD_HEADER) begin
			i = $urandom_range(0, MARK_LEN - 1);
			frame[i] = frame[i] ^ byte_t'($urandom_range(1, 255));
		end
		if (kind == SEQ_BAD_TAIL) begin
			i = FRAME_BYTES - MARK_LEN + $urandom_range(0, MARK_LEN - 1);
			frame[i] = frame[i] ^ byte_t'($urandom_range(1, 255));
		end
		for (i = 0; i < FRAME_BYTES; i++) begin
			send_byte(frame[i]);
		end
		if (kind == SEQ_GOOD_FRAME || kind == SEQ_MARKED_PAYLOAD) begin
			frames_sent++;
		end
	endtask

	// Payload back-pressure: random stall bursts, none in the closing part of the run.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		payload_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (quiet) begin
				payload_if.ready <= 1'b1;
			end else if (stall_left != 0) begin
				payload_if.ready <= 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 5) == 0) begin
				payload_if.ready <= 1'b0;
				stall_left = $urandom_range(0, 14);
			end else begin
				payload_if.ready <= 1'b1;
			end
		end
	end

	// Ends the run when no beat moves on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_if.valid && rx_if.ready) || (payload_if.valid && payload_if.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Reset, the corner bytes, then random frames and noise until enough have gone.
	initial begin
		int        seq_no;
		int        i;
		int        noise_len;
		seq_kind_t kind;
		arst_n          <= 1'b0;
		rx_if.valid     <= 1'b0;
		rx_if.data_byte <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (CORNER_BYTES[i]) begin
			send_byte(CORNER_BYTES[i]);
		end

		seq_no = 0;
		while (bytes_sent < TARGET_BYTES || frames_sent < TARGET_FRAMES) begin
			// Once a whole frame no longer fits in the byte budget, short noise fills it up.
			if (frames_sent >= TARGET_FRAMES && bytes_sent + FRAME_BYTES > TARGET_BYTES) begin
				kind = SEQ_NOISE;
			// Otherwise the first few sequences step through the kinds in order, one each.
			end else if (seq_no < SEQ_KINDS) begin
				kind = seq_kind_t'(seq_no);
			end else begin
				case ($urandom_range(0, 9))
					0: kind = SEQ_BAD_HEADER;
					1: kind = SEQ_BAD_TAIL;
					2, 3: kind = SEQ_MARKED_PAYLOAD;
					4: kind = SEQ_NOISE;
					default: kind = SEQ_GOOD_FRAME;
				endcase
			end
			if (kind == SEQ_NOISE) begin
				noise_len = $urandom_range(1, 20);
				for (i = 0; i < noise_len; i++) begin
					send_byte(mark_like_byte());
				end
			end else begin
				send_frame(kind);
			end
			seq_no++;
			if (frames_sent >= TARGET_FRAMES) begin
				quiet = 1'b1;
			end
		end
		rx_if.valid <= 1'b0;

		// Let every due beat arrive, then watch a little longer for strays.
		@(negedge clk);
		while (beats_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
